>>> sv/mlmd_pkg.sv
// ----------------------------------------------------------------------------
// Marker/length module deframer package
// Shared constants, codes and types for the deframer and its match window.
// ----------------------------------------------------------------------------
package mlmd_pkg;

    localparam int MAX_MARKER_BYTES_DEF = 8;
    localparam int MARKER_W             = 64;
    localparam int LEN_W                = 4;
    localparam int LEN_FIELD_BYTES      = 4;
    localparam int COUNT_W              = 32;
    localparam int CFG_IDX_W            = 8;
    localparam int IN_TDATA_W           = 8;
    localparam int OUT_TDATA_W          = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_BEGIN_MARKER = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BEGIN_LENGTH = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_LENGTH   = 8'd3;

    typedef enum logic [3:0] {
        PH_SEARCH  = 4'b0001,
        PH_LENGTH  = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_END     = 4'b1000
    } t_phase;

    typedef struct packed {
        logic push;
        logic clear;
    } t_win_ctl;

    typedef struct packed {
        logic match;
        logic filled;
    } t_win_sts;

endpackage

>>> sv/mlmd_window.sv
// ----------------------------------------------------------------------------
// Marker match window
// Shifts received bytes into a window, newest byte in the top lane, and
// compares the newest bytes against a marker of selectable length.
// ----------------------------------------------------------------------------
module mlmd_window
    import mlmd_pkg::*;
#(
    parameter int MAX_BYTES = MAX_MARKER_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_win_ctl            i_ctl,
    input  logic [7:0]          i_byte,
    input  logic [MARKER_W-1:0] i_marker,
    input  logic [LEN_W-1:0]    i_len,
    output t_win_sts            o_sts
);

    localparam int WIN_W = 8 * MAX_BYTES;

    logic [WIN_W-1:0] r_window;
    logic [WIN_W-1:0] n_window;
    logic [LEN_W-1:0] r_fill;
    logic [LEN_W-1:0] n_fill;
    logic [LEN_W-1:0] lane_shift;
    logic [WIN_W-1:0] aligned;
    logic [MAX_BYTES-1:0] lane_ok;

    always_comb begin
        n_window = r_window;
        n_fill   = r_fill;
        if (i_ctl.push) begin
            if (MAX_BYTES > 1) begin
                n_window = {i_byte, r_window[WIN_W-1:8]};
            end else begin
                n_window = WIN_W'(i_byte);
            end
            if (r_fill < LEN_W'(MAX_BYTES)) begin
                n_fill = r_fill + 1'b1;
            end
        end
    end

    assign lane_shift = LEN_W'(MAX_BYTES) - i_len;
    assign aligned    = n_window >> {lane_shift, 3'b000};

    always_comb begin
        for (int k = 0; k < MAX_BYTES; k++) begin
            lane_ok[k] = (LEN_W'(k) >= i_len) || (aligned[8*k +: 8] == i_marker[8*k +: 8]);
        end
    end

    assign o_sts.filled = (n_fill >= i_len);
    assign o_sts.match  = o_sts.filled && (&lane_ok);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_fill   <= '0;
        end else if (i_ctl.clear) begin
            r_window <= '0;
            r_fill   <= '0;
        end else begin
            r_window <= n_window;
            r_fill   <= n_fill;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= LEN_W'(MAX_BYTES))
        else $error("Window fill exceeds the window depth.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.clear |=> r_fill == '0)
        else $error("Window fill not cleared.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_ctl.push && !i_ctl.clear) |=> $stable(r_fill))
        else $error("Window fill changed without a push.");

endmodule

>>> sv/marker_length_module_deframer.sv
// ----------------------------------------------------------------------------
// Marker/length module deframer
// Finds a begin marker, reads a 4-byte big-endian length, flags the payload
// bytes and checks the end marker, producing one result item per input item.
// ----------------------------------------------------------------------------
// A result item is registered and appears in the cycle after its input item is accepted.
// Throughput: one item per cycle; the only storage between the sides is the
// single output register, so input is stalled only while that register holds
// an item the consumer has not taken.
// Reset: synchronous, active low; markers clear to zero, marker lengths to one,
// the block returns to the begin marker search with an empty window.
module marker_length_module_deframer
    import mlmd_pkg::*;
#(
    parameter int MAX_MARKER_BYTES = MAX_MARKER_BYTES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Fields from bit 0: in_byte[7:0].
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                   i_s_tlast,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // Fields from bit 0: out_byte[7:0], module_done[8], module_ok[9],
    // module_length[41:10], cut_short[42], zero fill[47:43].
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    // Fields from bit 0: payload_flag[0].
    output logic                   o_m_tuser,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [MARKER_W-1:0]    i_cfg_data
);

    logic [MARKER_W-1:0] r_begin_marker;
    logic [LEN_W-1:0]    r_begin_length;
    logic [MARKER_W-1:0] r_end_marker;
    logic [LEN_W-1:0]    r_end_length;

    t_phase              r_phase;
    t_phase              n_phase;
    logic [COUNT_W-1:0]  r_count;
    logic [COUNT_W-1:0]  n_count;
    logic [COUNT_W-1:0]  r_plen;
    logic [COUNT_W-1:0]  n_plen;

    logic                r_out_valid;
    logic [7:0]          r_out_byte;
    logic                r_out_pflag;
    logic                r_out_done;
    logic                r_out_ok;
    logic [COUNT_W-1:0]  r_out_mlen;
    logic                r_out_cut;

    logic                n_pflag;
    logic                n_done;
    logic                n_ok;
    logic [COUNT_W-1:0]  n_mlen;
    logic                n_cut;

    logic                accept;
    logic [7:0]          in_byte;
    logic [COUNT_W-1:0]  count_inc;
    logic [LEN_W-1:0]    begin_len_eff;
    logic [LEN_W-1:0]    end_len_eff;
    logic [LEN_W-1:0]    win_len;
    logic [MARKER_W-1:0] win_marker;
    t_win_ctl            win_ctl;
    t_win_sts            win_sts;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign accept      = i_s_tvalid && o_s_tready;
    assign in_byte     = i_s_tdata[7:0];
    assign count_inc   = r_count + 1'b1;

    always_comb begin
        begin_len_eff = r_begin_length;
        if (r_begin_length == '0) begin
            begin_len_eff = LEN_W'(1);
        end else if (r_begin_length > LEN_W'(MAX_MARKER_BYTES)) begin
            begin_len_eff = LEN_W'(MAX_MARKER_BYTES);
        end
        end_len_eff = r_end_length;
        if (r_end_length == '0) begin
            end_len_eff = LEN_W'(1);
        end else if (r_end_length > LEN_W'(MAX_MARKER_BYTES)) begin
            end_len_eff = LEN_W'(MAX_MARKER_BYTES);
        end
    end

    assign win_marker = (r_phase == PH_END) ? r_end_marker : r_begin_marker;
    assign win_len    = (r_phase == PH_END) ? end_len_eff : begin_len_eff;

    mlmd_window #(
        .MAX_BYTES (MAX_MARKER_BYTES)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (win_ctl),
        .i_byte   (in_byte),
        .i_marker (win_marker),
        .i_len    (win_len),
        .o_sts    (win_sts)
    );

    always_comb begin
        n_phase       = r_phase;
        n_count       = r_count;
        n_plen        = r_plen;
        n_pflag       = 1'b0;
        n_done        = 1'b0;
        n_ok          = 1'b0;
        n_mlen        = '0;
        n_cut         = 1'b0;
        win_ctl.push  = 1'b0;
        win_ctl.clear = 1'b0;
        case (r_phase)
            PH_SEARCH: begin
                win_ctl.push = accept;
                if (win_sts.match) begin
                    win_ctl.clear = accept;
                    n_phase       = PH_LENGTH;
                    n_count       = '0;
                    n_plen        = '0;
                end
            end
            PH_LENGTH: begin
                n_plen  = {r_plen[COUNT_W-9:0], in_byte};
                n_count = count_inc;
                if (count_inc >= COUNT_W'(LEN_FIELD_BYTES)) begin
                    n_mlen        = n_plen;
                    n_count       = '0;
                    win_ctl.clear = accept;
                    n_phase       = (n_plen == '0) ? PH_END : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_pflag = 1'b1;
                n_mlen  = r_plen;
                n_count = count_inc;
                if (count_inc >= r_plen) begin
                    n_count       = '0;
                    win_ctl.clear = accept;
                    n_phase       = PH_END;
                end
            end
            PH_END: begin
                n_mlen       = r_plen;
                win_ctl.push = accept;
                if (win_sts.filled) begin
                    n_done        = 1'b1;
                    n_ok          = win_sts.match;
                    win_ctl.clear = accept;
                    n_count       = '0;
                    n_phase       = PH_SEARCH;
                end
            end
            default: begin
                n_phase = PH_SEARCH;
            end
        endcase
        if (i_s_tlast) begin
            n_cut         = (n_phase != PH_SEARCH);
            win_ctl.clear = accept;
            n_count       = '0;
            n_phase       = PH_SEARCH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_begin_marker <= '0;
            r_begin_length <= LEN_W'(1);
            r_end_marker   <= '0;
            r_end_length   <= LEN_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BEGIN_MARKER: r_begin_marker <= i_cfg_data;
                CFG_BEGIN_LENGTH: r_begin_length <= i_cfg_data[LEN_W-1:0];
                CFG_END_MARKER:   r_end_marker   <= i_cfg_data;
                CFG_END_LENGTH:   r_end_length   <= i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SEARCH;
            r_count     <= '0;
            r_plen      <= '0;
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_plen      <= n_plen;
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_byte  <= in_byte;
            r_out_pflag <= n_pflag;
            r_out_done  <= n_done;
            r_out_ok    <= n_ok;
            r_out_mlen  <= n_mlen;
            r_out_cut   <= n_cut;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_pflag;
    assign o_m_tdata  = {5'b00000, r_out_cut, r_out_mlen, r_out_ok, r_out_done, r_out_byte};

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tlast) |=> r_phase == PH_SEARCH)
        else $error("Phase did not return to search after the buffer end.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && r_phase == PH_PAYLOAD) |=> (o_m_tvalid && o_m_tuser))
        else $error("Payload item not flagged.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> !o_s_tready)
        else $error("Input accepted while the result register is stalled.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && r_phase == PH_END && !i_s_tlast) |=>
            (o_m_tdata[8] == (r_phase == PH_SEARCH)))
        else $error("End marker check result disagrees with the phase.");

endmodule

>>> dv/marker_length_module_deframer_tb.sv
// ----------------------------------------------------------------------------
// Marker/length module deframer testbench
// Drives byte items with random gaps and random output stalls, predicts every
// result item with an independent model of the marker search, length field,
// payload and end marker check, and compares each result field by field.
// ----------------------------------------------------------------------------
module marker_length_module_deframer_tb;
    import mlmd_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 2000;
    localparam int PHASES       = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_PRINTED  = 40;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 8'hA5;

    typedef struct packed {
        logic        cut;
        logic [31:0] mlen;
        logic        ok;
        logic        done;
        logic        payload;
        logic [7:0]  data;
    } t_deframed;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic [IN_TDATA_W-1:0]  i_s_tdata   = '0;
    logic                   i_s_tlast   = 1'b0;
    logic                   i_s_tvalid  = 1'b0;
    logic                   o_s_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tuser;
    logic                   o_m_tvalid;
    logic                   i_m_tready  = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [MARKER_W-1:0]    i_cfg_data  = '0;

    marker_length_module_deframer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    logic [63:0] cfg_begin_marker = '0;
    logic [3:0]  cfg_begin_len    = 4'd1;
    logic [63:0] cfg_end_marker   = '0;
    logic [3:0]  cfg_end_len      = 4'd1;

    logic [63:0] win        = '0;
    int unsigned win_fill   = 0;
    t_phase      frame_ph   = PH_SEARCH;
    logic [31:0] frame_cnt  = '0;
    logic [31:0] frame_plen = '0;

    t_deframed   deframed_q[$];

    int          errors        = 0;
    int          items_sent    = 0;
    int          items_checked = 0;
    int          modules_sent  = 0;
    int          seen_ok       = 0;
    int          seen_bad      = 0;
    int          seen_cut      = 0;
    int          seen_payload  = 0;
    int          cycle_count   = 0;
    logic        no_idle       = 1'b0;
    logic        hold_request  = 1'b0;
    int          stall_left    = 0;
    int          rx_gap;
    t_deframed   want;
    t_deframed   got;

    function automatic int unsigned marker_bytes(logic [3:0] n);
        if (n == 4'd0) return 1;
        if (n > 4'd8) return 8;
        return n;
    endfunction

    function automatic void push_window(logic [7:0] b);
        win = {b, win[63:8]};
        if (win_fill < 8) win_fill++;
    endfunction

    function automatic void clear_window();
        win      = '0;
        win_fill = 0;
    endfunction

    function automatic logic window_hit(logic [63:0] marker, int unsigned n);
        logic [63:0] mask;
        if (win_fill < n) return 1'b0;
        mask = (n >= 8) ? '1 : ((64'h1 << (8 * n)) - 64'h1);
        return ((win >> (8 * (8 - n))) & mask) == (marker & mask);
    endfunction

    function automatic t_deframed deframe_byte(logic [7:0] b, logic last);
        t_deframed   r;
        int unsigned n;
        r      = '0;
        r.data = b;
        case (frame_ph)
            PH_SEARCH: begin
                push_window(b);
                if (window_hit(cfg_begin_marker, marker_bytes(cfg_begin_len))) begin
                    clear_window();
                    frame_ph   = PH_LENGTH;
                    frame_cnt  = '0;
                    frame_plen = '0;
                end
            end
            PH_LENGTH: begin
                frame_plen = {frame_plen[23:0], b};
                frame_cnt++;
                if (frame_cnt >= LEN_FIELD_BYTES) begin
                    r.mlen    = frame_plen;
                    frame_cnt = '0;
                    clear_window();
                    if (frame_plen == '0) frame_ph = PH_END;
                    else frame_ph = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                r.payload = 1'b1;
                r.mlen    = frame_plen;
                frame_cnt++;
                if (frame_cnt >= frame_plen) begin
                    frame_cnt = '0;
                    clear_window();
                    frame_ph = PH_END;
                end
            end
            default: begin
                r.mlen = frame_plen;
                push_window(b);
                n = marker_bytes(cfg_end_len);
                if (win_fill >= n) begin
                    r.done = 1'b1;
                    r.ok   = window_hit(cfg_end_marker, n);
                    clear_window();
                    frame_cnt = '0;
                    frame_ph  = PH_SEARCH;
                end
            end
        endcase
        if (last) begin
            if (frame_ph != PH_SEARCH) r.cut = 1'b1;
            clear_window();
            frame_cnt = '0;
            frame_ph  = PH_SEARCH;
        end
        return r;
    endfunction

    function automatic int idle_len();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 80) return 0;
        if (r < 96) return $urandom_range(1, 3);
        return $urandom_range(15, 40);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] exp_v,
                                   input logic [63:0] got_v);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("mismatch at result %0d: %s expected %0h got %0h",
                     items_checked, what, exp_v, got_v);
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** marker_length_module_deframer: FAILED **");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = HOLD_CYCLES;
        end
        if (stall_left > 0) begin
            i_m_tready <= 1'b0;
            stall_left--;
        end else begin
            rx_gap = idle_len();
            if (rx_gap > 0) begin
                i_m_tready <= 1'b0;
                stall_left = rx_gap - 1;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.data    = o_m_tdata[7:0];
            got.done    = o_m_tdata[8];
            got.ok      = o_m_tdata[9];
            got.mlen    = o_m_tdata[41:10];
            got.cut     = o_m_tdata[42];
            got.payload = o_m_tuser;
            if (deframed_q.size() == 0) begin
                report_mismatch("result with nothing expected", '0, 64'(o_m_tdata));
            end else begin
                want = deframed_q.pop_front();
                if (got.data != want.data)
                    report_mismatch("out_byte", 64'(want.data), 64'(got.data));
                if (got.payload != want.payload)
                    report_mismatch("payload_flag", 64'(want.payload), 64'(got.payload));
                if (got.done != want.done)
                    report_mismatch("module_done", 64'(want.done), 64'(got.done));
                if (got.ok != want.ok)
                    report_mismatch("module_ok", 64'(want.ok), 64'(got.ok));
                if (got.mlen != want.mlen)
                    report_mismatch("module_length", 64'(want.mlen), 64'(got.mlen));
                if (got.cut != want.cut)
                    report_mismatch("cut_short", 64'(want.cut), 64'(got.cut));
                if (want.done && want.ok) seen_ok++;
                if (want.done && !want.ok) seen_bad++;
                if (want.cut) seen_cut++;
                if (want.payload) seen_payload++;
            end
            items_checked++;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        deframed_q.insert(deframed_q.size(), deframe_byte(b, last));
        items_sent++;
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (deframed_q.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_BEGIN_MARKER: cfg_begin_marker = value;
            CFG_BEGIN_LENGTH: cfg_begin_len    = value[3:0];
            CFG_END_MARKER:   cfg_end_marker   = value;
            CFG_END_LENGTH:   cfg_end_len      = value[3:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_markers(input logic [63:0] bm, input logic [3:0] bl,
                               input logic [63:0] em, input logic [3:0] el);
        wait_drained();
        cfg_write(CFG_BEGIN_MARKER, bm);
        cfg_write(CFG_BEGIN_LENGTH, {60'd0, bl});
        cfg_write(CFG_END_MARKER, em);
        cfg_write(CFG_END_LENGTH, {60'd0, el});
        cfg_write(CFG_UNUSED_INDEX, {$urandom, $urandom});
    endtask

    task automatic send_noise(input int count);
        repeat (count) send_byte(8'($urandom), ($urandom_range(0, 19) == 0));
    endtask

    task automatic send_module();
        logic [8:0]  seq[$];
        logic [31:0] len;
        logic [63:0] endm;
        int          nb;
        int          ne;
        int          r;
        int          pos;
        nb = marker_bytes(cfg_begin_len);
        ne = marker_bytes(cfg_end_len);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) seq.insert(seq.size(), {1'b0, 8'($urandom)});
        for (int i = 0; i < nb; i++)
            seq.insert(seq.size(), {1'b0, cfg_begin_marker[8*i +: 8]});
        r = $urandom_range(0, 99);
        if (r < 8) len = $urandom;
        else if (r < 16) len = '0;
        else len = $urandom_range(1, 12);
        for (int i = 3; i >= 0; i--) seq.insert(seq.size(), {1'b0, len[8*i +: 8]});
        if (len > 32'd16) begin
            // A huge length can never finish here, so the buffer ends inside it.
            repeat ($urandom_range(0, 5)) seq.insert(seq.size(), {1'b0, 8'($urandom)});
            seq[seq.size()-1][8] = 1'b1;
        end else begin
            for (int i = 0; i < len; i++) seq.insert(seq.size(), {1'b0, 8'($urandom)});
            endm = cfg_end_marker;
            if ($urandom_range(0, 3) == 0) begin
                pos = $urandom_range(0, ne - 1);
                endm[8*pos +: 8] = endm[8*pos +: 8] ^ 8'($urandom_range(1, 255));
            end
            for (int i = 0; i < ne; i++) seq.insert(seq.size(), {1'b0, endm[8*i +: 8]});
            r = $urandom_range(0, 99);
            if (r < 10) seq[$urandom_range(0, seq.size() - 1)][8] = 1'b1;
            else if (r < 35) seq[seq.size()-1][8] = 1'b1;
        end
        foreach (seq[i]) send_byte(seq[i][7:0], seq[i][8]);
        modules_sent++;
    endtask

    task automatic test_reset_markers();
        // Zero payload length straight into a failing end marker check.
        send_byte(8'h00, 1'b0);
        repeat (4) send_byte(8'h00, 1'b0);
        send_byte(8'h7E, 1'b0);
    endtask

    task automatic test_multi_byte_markers();
        set_markers(64'h0000_0000_0000_444D, 4'd3, 64'h0000_0000_0000_0045, 4'd2);
        // A repeated first marker byte, then a module completing on the buffer end.
        send_byte(8'h4D, 1'b0);
        send_byte(8'h4D, 1'b0);
        send_byte(8'h44, 1'b0);
        send_byte(8'h00, 1'b0);
        repeat (3) send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h45, 1'b0);
        send_byte(8'h00, 1'b1);
        // The buffer ends inside the length field.
        send_byte(8'h4D, 1'b0);
        send_byte(8'h44, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_length_limits();
        // Length 0 acts as one byte and 15 as eight bytes.
        set_markers('1, 4'd0, '1, 4'd15);
        send_byte(8'hFF, 1'b0);
        repeat (4) send_byte(8'h00, 1'b0);
        repeat (8) send_byte(8'hFF, 1'b0);
    endtask

    task automatic test_back_pressure();
        wait_drained();
        no_idle      = 1'b1;
        hold_request = 1'b1;
        repeat (3) send_module();
        no_idle = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_modules();
        logic [63:0] bm;
        logic [63:0] em;
        logic [3:0]  bl;
        logic [3:0]  el;
        int          stop_at;
        for (int p = 0; p < PHASES; p++) begin
            bm = {$urandom, $urandom};
            em = {$urandom, $urandom};
            bl = 4'($urandom_range(0, 15));
            el = 4'($urandom_range(0, 15));
            if ($urandom_range(0, 1) == 1) bm[8*(marker_bytes(bl)-1) +: 8] = 8'h00;
            if ($urandom_range(0, 1) == 1) em[8*(marker_bytes(el)-1) +: 8] = 8'h00;
            case (p)
                0: set_markers('1, 4'd8, '1, 4'd8);
                1: set_markers('0, 4'd1, '0, 4'd1);
                2: set_markers(bm, 4'd8, em, 4'd1);
                default: set_markers(bm, bl, em, el);
            endcase
            no_idle = (p == 3);
            stop_at = items_sent + RANDOM_ITEMS / PHASES;
            while (items_sent < stop_at) begin
                if ($urandom_range(0, 9) == 0) send_noise($urandom_range(1, 6));
                else send_module();
            end
            no_idle = 1'b0;
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_markers();
        test_multi_byte_markers();
        test_length_limits();
        test_back_pressure();
        test_random_modules();
        wait_drained();
        repeat (5) @(posedge i_clk);
        $display("sent %0d items in %0d module sequences, compared %0d results",
                 items_sent, modules_sent, items_checked);
        $display("modules accepted %0d, rejected %0d, cut short %0d, payload bytes %0d",
                 seen_ok, seen_bad, seen_cut, seen_payload);
        if (errors == 0) begin
            $display("** marker_length_module_deframer: PASSED **");
        end else begin
            $display("%0d mismatches", errors);
            $display("** marker_length_module_deframer: FAILED **");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/mlmd_pkg.sv
sv/mlmd_window.sv
sv/marker_length_module_deframer.sv
dv/marker_length_module_deframer_tb.sv
